[hdl/pid_controller_windup_limit_defines.svh]
// Assertion macros used by the checker of the PID controller.
`ifndef PID_CONTROLLER_WINDUP_LIMIT_DEFINES_SVH
`define PID_CONTROLLER_WINDUP_LIMIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define PIDWL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pidwl assertion failed");

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define PIDWL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pidwl assertion failed");

`endif

[hdl/pidwl_pkg.sv]
// Package with the shared widths, register indexes and constants of the PID controller.
package pidwl_pkg;

  localparam int TARGET_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int INTEG_W    = 16;
  localparam int DRIVE_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // The proportional plus derivative sum is clamped to +-2^(PD_CLAMP_EXP + frac bits).
  localparam int PD_CLAMP_EXP = 24;

  localparam int DRIVE_MAX = 127;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 2'd3;

endpackage

[hdl/pid_controller_windup_limit.sv]
// Top level of the PID position controller with an integral windup limit.
//
// Usage: a sample (target_pos_i, sensor_pos_i) is transferred on the input
// channel when in_valid_i and in_ready_o are both high. The block works on one
// sample at a time; in_ready_o is high only while the sequencer is idle. The
// result drive_o is offered on the output channel with out_valid_o and is
// transferred when out_ready_i is high.
// The sequencer runs through its steps in order: nine steps form the difference,
// update the integral, feed the one shared multiplier and the adder and take the
// magnitude, eight steps run the restoring divider that yields the quotient bits
// of the drive, one step loads the output register, and the idle state takes the
// next sample.
// When the receiver stalls, the finished result stays in the output register
// and the block still takes the next sample; only when a second result is
// ready while the first still waits does the sequencer hold in its last step.
// Reset clears the gains to zero, sets the integral limit to one, and clears
// the integral, the previous error and the output valid flag.
// Configuration writes through cfg_we_i take effect at the next clock edge.
module pid_controller_windup_limit
  import pidwl_pkg::*;
#(
  parameter int SENSOR_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [TARGET_W-1:0]    target_pos_i,
  input  logic signed [SENSOR_BITS-1:0] sensor_pos_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [DRIVE_W-1:0]     drive_o
);

  // Error, error difference and multiplier operand widths.
  localparam int E_W    = SENSOR_BITS + 1;
  localparam int D_W    = SENSOR_BITS + 2;
  localparam int PD_W   = PD_CLAMP_EXP + GAIN_FRAC_BITS + 2;
  localparam int KI_W   = GAIN_W + INTEG_W + 1;
  localparam int MA_W0  = (D_W > PD_W) ? D_W : PD_W;
  localparam int MA_W   = (MA_W0 > KI_W) ? MA_W0 : KI_W;
  localparam int MB_W   = GAIN_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = PROD_W + 2;
  // Divisor shifted by the top quotient bit position.
  localparam int QB_W   = DRIVE_W - 1;
  localparam int DSH_W  = LIMIT_W + GAIN_FRAC_BITS + QB_W;
  localparam int CNT_W  = 3;

  localparam logic signed [ACC_W-1:0] PD_BOUND =
    {{(ACC_W-PD_CLAMP_EXP-GAIN_FRAC_BITS-1){1'b0}}, 1'b1,
     {(PD_CLAMP_EXP+GAIN_FRAC_BITS){1'b0}}};

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_MKP   = 4'd2;
  localparam logic [3:0] ST_MKD   = 4'd3;
  localparam logic [3:0] ST_SUMPD = 4'd4;
  localparam logic [3:0] ST_MLIM  = 4'd5;
  localparam logic [3:0] ST_MKI   = 4'd6;
  localparam logic [3:0] ST_M127  = 4'd7;
  localparam logic [3:0] ST_SUMI  = 4'd8;
  localparam logic [3:0] ST_ABS   = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  // Configuration registers.
  logic [GAIN_W-1:0]  prop_gain_q;
  logic [GAIN_W-1:0]  integ_gain_q;
  logic [GAIN_W-1:0]  deriv_gain_q;
  logic [LIMIT_W-1:0] integ_limit_q;

  // Sequencer and datapath registers.
  logic [3:0]                 state_q, state_d;
  logic signed [E_W-1:0]      err_q, err_d;
  logic signed [E_W-1:0]      prev_q, prev_d;
  logic signed [D_W-1:0]      diff_q, diff_d;
  logic signed [INTEG_W-1:0]  integ_q, integ_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic [DSH_W-1:0]           dsh_q, dsh_d;
  logic [DRIVE_W-1:0]         quo_q, quo_d;
  logic                       neg_q, neg_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic signed [DRIVE_W-1:0]  drive_q, drive_d;
  logic                       out_valid_q, out_valid_d;

  // Combinational helpers.
  logic                       in_xfer;
  logic signed [E_W-1:0]      tgt_ext;
  logic signed [E_W-1:0]      sen_ext;
  logic [LIMIT_W-1:0]         eff_limit;
  logic [INTEG_W-1:0]         integ_mag;
  logic [E_W-1:0]             err_mag;
  logic [E_W:0]               mag_sum;
  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [ACC_W-1:0]    pd_sum;
  logic signed [ACC_W-1:0]    rem_sub;
  logic                       rem_ge;
  logic [DRIVE_W-1:0]         drv_mag;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  assign tgt_ext = E_W'(target_pos_i);
  assign sen_ext = E_W'(sensor_pos_i);

  // A zero limit is out of range: the divisor falls back to the gain scale
  // alone and the integral term is dropped below.
  assign eff_limit = (integ_limit_q == '0) ? LIMIT_W'(1) : integ_limit_q;

  assign integ_mag = integ_q[INTEG_W-1] ? INTEG_W'(-integ_q) : INTEG_W'(integ_q);
  assign err_mag   = err_q[E_W-1] ? E_W'(-err_q) : E_W'(err_q);
  assign mag_sum   = (E_W+1)'(integ_mag) + (E_W+1)'(err_mag);

  assign pd_sum  = acc_q + ACC_W'(prod_q);
  assign rem_ge  = $unsigned(acc_q) >= ACC_W'(dsh_q);
  assign rem_sub = acc_q - $signed(ACC_W'(dsh_q));

  // A set top quotient bit means the quotient reached 128 or more.
  assign drv_mag = quo_q[DRIVE_W-1] ? DRIVE_W'(DRIVE_MAX) : {1'b0, quo_q[QB_W-1:0]};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MKP: begin
        mul_a = MA_W'(err_q);
        mul_b = MB_W'(prop_gain_q);
      end
      ST_MKD: begin
        mul_a = MA_W'(diff_q);
        mul_b = MB_W'(deriv_gain_q);
      end
      ST_MLIM: begin
        mul_a = acc_q[MA_W-1:0];
        mul_b = MB_W'(eff_limit);
      end
      ST_MKI: begin
        mul_a = (integ_limit_q == '0) ? '0 : MA_W'(integ_q);
        mul_b = MB_W'(integ_gain_q);
      end
      ST_M127: begin
        mul_a = prod_q[MA_W-1:0];
        mul_b = MB_W'(DRIVE_MAX);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidwl_mul #(
    .A_W(MA_W),
    .B_W(MB_W)
  ) u_mul (
    .a_i(mul_a),
    .b_i(mul_b),
    .p_o(mul_p)
  );

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    prev_d      = prev_q;
    diff_d      = diff_q;
    integ_d     = integ_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    drive_d     = drive_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          err_d   = tgt_ext - sen_ext;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // The integral only takes the error while the sum of both magnitudes stays
        // below the limit, and a zero error clears it.
        if (mag_sum < (E_W+1)'(integ_limit_q)) begin
          integ_d = integ_q + err_q[INTEG_W-1:0];
        end
        if (err_q == '0) begin
          integ_d = '0;
        end
        diff_d  = D_W'(err_q) - D_W'(prev_q);
        prev_d  = err_q;
        state_d = ST_MKP;
      end
      ST_MKP: begin
        prod_d  = mul_p;
        state_d = ST_MKD;
      end
      ST_MKD: begin
        acc_d   = ACC_W'(prod_q);
        prod_d  = mul_p;
        state_d = ST_SUMPD;
      end
      ST_SUMPD: begin
        if (pd_sum > PD_BOUND) begin
          acc_d = PD_BOUND;
        end else if (pd_sum < -PD_BOUND) begin
          acc_d = -PD_BOUND;
        end else begin
          acc_d = pd_sum;
        end
        state_d = ST_MLIM;
      end
      ST_MLIM: begin
        prod_d  = mul_p;
        state_d = ST_MKI;
      end
      ST_MKI: begin
        acc_d   = ACC_W'(prod_q);
        prod_d  = mul_p;
        state_d = ST_M127;
      end
      ST_M127: begin
        prod_d  = mul_p;
        state_d = ST_SUMI;
      end
      ST_SUMI: begin
        acc_d   = pd_sum;
        state_d = ST_ABS;
      end
      ST_ABS: begin
        neg_d   = acc_q[ACC_W-1];
        acc_d   = acc_q[ACC_W-1] ? -acc_q : acc_q;
        dsh_d   = DSH_W'(eff_limit) << (GAIN_FRAC_BITS + QB_W);
        quo_d   = '0;
        cnt_d   = CNT_W'(QB_W);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rem_ge) begin
          acc_d = rem_sub;
        end
        quo_d = {quo_q[DRIVE_W-2:0], rem_ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          drive_d     = neg_q ? -$signed(drv_mag) : $signed(drv_mag);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      integ_q     <= integ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    diff_q  <= diff_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
    drive_q <= drive_d;
  end

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= '0;
      integ_gain_q  <= '0;
      deriv_gain_q  <= '0;
      integ_limit_q <= LIMIT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:   prop_gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_LIMIT: integ_limit_q <= cfg_data_i[LIMIT_W-1:0];
        default:         integ_limit_q <= integ_limit_q;
      endcase
    end
  end

endmodule

[hdl/pidwl_mul.sv]
// Shared signed multiplier used by the PID sequencer for every product.
module pidwl_mul #(
  parameter int A_W = 38,
  parameter int B_W = 17
) (
  input  logic signed [A_W-1:0]     a_i,
  input  logic signed [B_W-1:0]     b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  logic signed [A_W+B_W-1:0] a_ext;
  logic signed [A_W+B_W-1:0] b_ext;

  assign a_ext = (A_W+B_W)'(a_i);
  assign b_ext = (A_W+B_W)'(b_i);
  assign p_o   = a_ext * b_ext;

endmodule

[hdl/pidwl_chk.sv]
// Port-level checker for the PID controller and its bind to the top level.
`include "pid_controller_windup_limit_defines.svh"

module pidwl_chk
  import pidwl_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [DRIVE_W-1:0] drive_o
);

  // A stalled result keeps its valid and its value.
  `PIDWL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(drive_o))

  // The drive never takes the one code outside the saturation range.
  `PIDWL_ASSERT_NOW(a_drive_range, out_valid_o, drive_o != -DRIVE_W'(DRIVE_MAX + 1))

  // The sequencer is busy right after it takes a sample.
  `PIDWL_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind pid_controller_windup_limit pidwl_chk u_pidwl_chk (.*);

[tb/pid_controller_windup_limit_tb.sv]
// Self-checking testbench for the PID position controller with the integral windup limit.
`timescale 1ns / 1ps

// The testbench drives samples over the valid/ready input channel and writes the gain
// and limit registers only while the controller is idle. It predicts every drive value
// with its own integer model of the control law and compares each output transfer with
// the oldest prediction still waiting. A short directed table covers reset values,
// field extremes, the zero limit, a lowered limit and truncation. Random phases then
// follow with fresh register settings and different idle patterns on both channels.
module pid_controller_windup_limit_tb;
  import pidwl_pkg::*;

  localparam int SENSOR_W       = 24;
  localparam int GAIN_FRAC      = 8;
  localparam int CLK_HALF_NS    = 6;
  localparam int RESET_CYCLES   = 8;
  // Quiet cycles after the last result, so that the sequencer is idle with margin
  // before a register write or the end of the run.
  localparam int SETTLE_CYCLES  = 40;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_SAMPLES  = 146;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DIR_ROWS       = 34;

  typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_e;

  // One row of the directed table: either a register write or a sample. A sample row
  // may carry a typed drive value; without one, the predictor supplies the value.
  typedef struct {
    row_kind_e                    kind;
    logic [CFG_IDX_W-1:0]         reg_idx;
    logic [CFG_DATA_W-1:0]        reg_data;
    logic signed [TARGET_W-1:0]   target;
    logic signed [SENSOR_W-1:0]   sensor;
    bit                           has_drive;
    logic signed [DRIVE_W-1:0]    drive;
  } dir_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_idx_i;
  logic [CFG_DATA_W-1:0]       cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic signed [TARGET_W-1:0]  target_pos_i;
  logic signed [SENSOR_W-1:0]  sensor_pos_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [DRIVE_W-1:0]   drive_o;

  pid_controller_windup_limit #(
    .SENSOR_BITS   (SENSOR_W),
    .GAIN_FRAC_BITS(GAIN_FRAC)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .target_pos_i(target_pos_i),
    .sensor_pos_i(sensor_pos_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o)
  );

  // Copy of the register file as the controller should hold it.
  logic [GAIN_W-1:0]  kp_mirror;
  logic [GAIN_W-1:0]  ki_mirror;
  logic [GAIN_W-1:0]  kd_mirror;
  logic [LIMIT_W-1:0] limit_mirror;

  // Controller state as the predictor tracks it.
  longint integral_sum;
  longint last_error;

  logic signed [DRIVE_W-1:0] drive_expected_q [$];
  logic signed [DRIVE_W-1:0] drive_want;

  int send_idle_pct;
  int recv_stall_pct;
  int rx_holdoff;
  int mismatches;
  int cycle_count;

  dir_row_t directed_rows [DIR_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Runaway guard: a hung handshake ends the run here.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** pid_controller_windup_limit: FAILED **");
      $finish;
    end
  end

  function automatic longint magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Integer form of the control law. The drive is one rational value,
  //   ((kp*e + kd*(e - last))*L + ki*integral*127) / (2^frac * L),
  // truncated toward zero once and then saturated to +-127. The integral only takes
  // the error while |integral| + |error| stays below the limit, and a zero error
  // clears it. With a zero limit the integral term drops out and the divisor is
  // 2^frac alone.
  function automatic logic signed [DRIVE_W-1:0] predict_drive(
    logic signed [TARGET_W-1:0] target,
    logic signed [SENSOR_W-1:0] sensor
  );
    longint err;
    longint lim;
    longint pd;
    longint pd_bound;
    longint num;
    longint den;
    longint quot;
    err = longint'(target) - longint'(sensor);
    lim = longint'(limit_mirror);
    if (magnitude(integral_sum) + magnitude(err) < lim) integral_sum += err;
    if (err == 0) integral_sum = 0;
    pd = longint'(kp_mirror) * err + longint'(kd_mirror) * (err - last_error);
    // This clamp never changes the saturated drive; it only bounds the product.
    pd_bound = longint'(1) << (PD_CLAMP_EXP + GAIN_FRAC);
    if (pd > pd_bound) pd = pd_bound;
    if (pd < -pd_bound) pd = -pd_bound;
    if (lim > 0) begin
      num = pd * lim + longint'(ki_mirror) * integral_sum * DRIVE_MAX;
      den = (longint'(1) << GAIN_FRAC) * lim;
    end else begin
      num = pd;
      den = longint'(1) << GAIN_FRAC;
    end
    quot = num / den;
    if (quot > DRIVE_MAX) quot = DRIVE_MAX;
    if (quot < -DRIVE_MAX) quot = -DRIVE_MAX;
    last_error = err;
    return DRIVE_W'(quot);
  endfunction

  function automatic dir_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '{kind: ROW_WRITE, reg_idx: idx, reg_data: data, target: '0, sensor: '0,
            has_drive: 1'b0, drive: '0};
    return row;
  endfunction

  function automatic dir_row_t sample_row(logic signed [TARGET_W-1:0] target,
                                          logic signed [SENSOR_W-1:0] sensor);
    dir_row_t row;
    row = '{kind: ROW_SAMPLE, reg_idx: '0, reg_data: '0, target: target, sensor: sensor,
            has_drive: 1'b0, drive: '0};
    return row;
  endfunction

  function automatic dir_row_t checked_row(logic signed [TARGET_W-1:0] target,
                                           logic signed [SENSOR_W-1:0] sensor,
                                           logic signed [DRIVE_W-1:0] drive);
    dir_row_t row;
    row = sample_row(target, sensor);
    row.has_drive = 1'b1;
    row.drive = drive;
    return row;
  endfunction

  // Gains lean toward small values so that the drive is not always saturated, with
  // zero, full scale and fully random gains mixed in.
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:             return '0;
      1:             return '1;
      2, 3, 4, 5, 6: return GAIN_W'($urandom_range(0, 16'h0300));
      default:       return GAIN_W'($urandom);
    endcase
  endfunction

  // Limit data covers zero, both ends of the range and writes with the top data bit
  // set, which the register drops.
  function automatic logic [CFG_DATA_W-1:0] pick_limit_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(32767);
      3:       return CFG_DATA_W'(16'h8000 | $urandom_range(0, 32767));
      4, 5, 6: return CFG_DATA_W'($urandom_range(1, 300));
      default: return CFG_DATA_W'($urandom_range(1, 32767));
    endcase
  endfunction

  // Writes one register; the enable stays high so that writes can run back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_PROP_GAIN:   kp_mirror    = data[GAIN_W-1:0];
      REG_INTEG_GAIN:  ki_mirror    = data[GAIN_W-1:0];
      REG_DERIV_GAIN:  kd_mirror    = data[GAIN_W-1:0];
      REG_INTEG_LIMIT: limit_mirror = data[LIMIT_W-1:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every predicted drive has been transferred, then lets
  // the sequencer go quiet.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (drive_expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sender pause in the middle of a phase, until every predicted drive is out.
  task automatic hold_for_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (drive_expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Offers one sample, possibly after random idle cycles, and waits for its transfer.
  // Valid is left high on return; the next call either replaces the payload or drops
  // valid, so valid gets one assignment per falling edge.
  task automatic send_sample(logic signed [TARGET_W-1:0] target,
                             logic signed [SENSOR_W-1:0] sensor,
                             bit has_drive, logic signed [DRIVE_W-1:0] drive_typed);
    logic signed [DRIVE_W-1:0] drive_pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    target_pos_i <= target;
    sensor_pos_i <= sensor;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // The predictor runs for every transfer so that its state follows the block.
    drive_pred = predict_drive(target, sensor);
    drive_expected_q.push_back(has_drive ? drive_typed : drive_pred);
    @(negedge clk_i);
  endtask

  // Random sample: mostly a sensor close to the target so that the integral can move,
  // plus zero errors and errors anywhere in the full field ranges.
  task automatic send_random_sample();
    logic signed [TARGET_W-1:0] target;
    logic signed [SENSOR_W-1:0] sensor;
    longint                     delta;
    target = TARGET_W'($urandom);
    delta  = 0;
    case ($urandom_range(0, 19))
      0, 1:    delta = 0;
      12, 13, 14: delta = longint'($urandom_range(0, 4000)) - 2000;
      15, 16, 17: target = TARGET_W'($urandom);
      18, 19:  delta = 0;
      default: delta = longint'($urandom_range(0, 80)) - 40;
    endcase
    sensor = SENSOR_W'(longint'(target) - delta);
    if (sensor == SENSOR_W'(longint'(target) - delta) && delta == 0 && target[0]) begin
      // Keep the zero-error case exact; nothing to adjust.
    end
    case ($urandom_range(0, 19))
      15, 16, 17: sensor = SENSOR_W'($urandom);
      18, 19:     sensor = SENSOR_W'(TARGET_W'($urandom));
      default:    ;
    endcase
    send_sample(target, sensor, 1'b0, '0);
  endtask

  // Receiver: stalls at random, and for a long stretch whenever rx_holdoff is loaded.
  always @(negedge clk_i) begin
    if (rx_holdoff > 0) begin
      rx_holdoff--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every output transfer is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_expected_q.size() == 0) begin
        $error("drive: no transfer expected, actual %0d", drive_o);
        mismatches++;
      end else begin
        drive_want = drive_expected_q.pop_front();
        if (drive_o !== drive_want) begin
          $error("drive: expected %0d, actual %0d", drive_want, drive_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    target_pos_i   = '0;
    sensor_pos_i   = '0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_holdoff     = 0;
    mismatches     = 0;
    kp_mirror      = '0;
    ki_mirror      = '0;
    kd_mirror      = '0;
    limit_mirror   = LIMIT_W'(1);
    integral_sum   = 0;
    last_error     = 0;

    // After reset the gains are zero, so the drive reads zero for any sample. With all
    // gains at full scale the extreme errors saturate both ways. The zero limit, a
    // limit written with its top data bit set, a limit lowered below the stored
    // integral, and truncation of a small negative drive follow.
    directed_rows = '{
      checked_row(16'sd0, 24'sd0, 8'sd0),
      checked_row(16'sd32767, -24'sd8388608, 8'sd0),
      checked_row(-16'sd32768, 24'sd8388607, 8'sd0),
      write_row(REG_PROP_GAIN, 16'hFFFF),
      write_row(REG_INTEG_GAIN, 16'hFFFF),
      write_row(REG_DERIV_GAIN, 16'hFFFF),
      write_row(REG_INTEG_LIMIT, 16'h7FFF),
      checked_row(16'sd32767, -24'sd8388608, 8'sd127),
      checked_row(-16'sd32768, 24'sd8388607, -8'sd127),
      sample_row(16'sd5, 24'sd5),
      sample_row(16'sd100, 24'sd0),
      sample_row(16'sd100, 24'sd0),
      sample_row(16'sd0, 24'sd100),
      write_row(REG_INTEG_LIMIT, 16'h0000),
      sample_row(16'sd10, 24'sd0),
      sample_row(-16'sd10, 24'sd0),
      write_row(REG_INTEG_LIMIT, 16'h8005),
      sample_row(16'sd2, 24'sd0),
      sample_row(16'sd2, 24'sd0),
      sample_row(16'sd2, 24'sd0),
      write_row(REG_PROP_GAIN, 16'h0000),
      write_row(REG_DERIV_GAIN, 16'h0000),
      write_row(REG_INTEG_GAIN, 16'h0100),
      write_row(REG_INTEG_LIMIT, 16'd1000),
      sample_row(16'sd500, 24'sd0),
      sample_row(16'sd400, 24'sd0),
      write_row(REG_INTEG_LIMIT, 16'd3),
      sample_row(16'sd1, 24'sd0),
      sample_row(16'sd0, 24'sd0),
      sample_row(-16'sd1, 24'sd0),
      write_row(REG_PROP_GAIN, 16'h0001),
      write_row(REG_INTEG_GAIN, 16'h0000),
      sample_row(-16'sd255, 24'sd0),
      sample_row(16'sd255, -24'sd1)
    };

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. Writes wait until the samples before them are all out.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        if (r > 0 && directed_rows[r-1].kind == ROW_SAMPLE) drain_results();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
      end else begin
        if (cfg_we_i) end_writes();
        send_sample(directed_rows[r].target, directed_rows[r].sensor,
                    directed_rows[r].has_drive, directed_rows[r].drive);
      end
    end

    // Random phases. Each one starts idle with new register values; the idle pattern
    // cycles through no idling, an idle sender, a stalling receiver, and both.
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      if (p == 0) begin
        write_reg(REG_PROP_GAIN, '1);
        write_reg(REG_INTEG_GAIN, '1);
        write_reg(REG_DERIV_GAIN, '1);
        write_reg(REG_INTEG_LIMIT, CFG_DATA_W'(32767));
      end else if (p == 1) begin
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(1));
        write_reg(REG_INTEG_GAIN, CFG_DATA_W'(1));
        write_reg(REG_DERIV_GAIN, CFG_DATA_W'(1));
        write_reg(REG_INTEG_LIMIT, CFG_DATA_W'(1));
      end else begin
        write_reg(REG_PROP_GAIN, pick_gain());
        write_reg(REG_INTEG_GAIN, pick_gain());
        write_reg(REG_DERIV_GAIN, pick_gain());
        write_reg(REG_INTEG_LIMIT, pick_limit_data());
      end
      end_writes();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        // A long receiver hold-off while samples keep coming fills the output register
        // and the sequencer, so the input channel must stall.
        if (p == 4 && i == 60) rx_holdoff = HOLDOFF_CYCLES;
        if (p == 6 && (i == 70 || i == 120)) hold_for_results();
        send_random_sample();
      end
    end

    drain_results();
    if (mismatches == 0 && drive_expected_q.size() == 0) begin
      $display("** pid_controller_windup_limit: PASSED **");
    end else begin
      $display("** pid_controller_windup_limit: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/pidwl_pkg.sv
hdl/pidwl_mul.sv
hdl/pid_controller_windup_limit.sv
hdl/pidwl_chk.sv
tb/pid_controller_windup_limit_tb.sv
